@@ rtl/gf2anf_pkg.sv @@
// shared types and constants for the gf2 anf polynomial evaluator
// no dependencies
package gf2anf_pkg;

   localparam int NUM_VARS  = 64;
   localparam int NUM_POLYS = 8;
   localparam int MAX_TERMS = 16;

   localparam int FIELD_W   = 64;
   localparam int RESULT_W  = 8;
   localparam int ACTIVE_W  = 4;
   localparam int TERM_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int POLY_W    = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;

   localparam logic [FIELD_W-1:0] VAR_MASK =
      (NUM_VARS >= FIELD_W) ? {FIELD_W{1'b1}} : ((FIELD_W'(1) << NUM_VARS) - FIELD_W'(1));

   typedef enum logic [1:0] {
      CMD_WRITE_MASK  = 2'd0,
      CMD_WRITE_COUNT = 2'd1,
      CMD_EVALUATE    = 2'd2,
      CMD_RESERVED    = 2'd3
   } cmd_type;

   typedef logic [NUM_POLYS-1:0][NUM_VARS-1:0] mask_row_type;
   typedef logic [NUM_POLYS-1:0][CNT_W-1:0]    count_vec_type;

   typedef struct packed {
      logic              clear;
      logic              step;
      logic [TERM_W-1:0] slot;
   } acc_ctl_type;

endpackage

@@ rtl/gf2_anf_polynomial_evaluator.sv @@
// gf2 anf polynomial evaluator top level: command decode, sequencer, term counts
// depends on gf2anf_pkg, gf2anf_term_store, gf2anf_accum
//
// usage: a command is transferred at a rising edge with start high and busy low.
// req_command selects write term mask, write term count or evaluate; the other
// req_ ports carry the operands. writes take effect at the transfer edge, never
// raise busy and give no result, so one write per cycle is possible while busy is low.
// an evaluate walks one term slot per cycle across all polynomials at once,
// reading one row of the term memory per cycle: ST_RUN issues the reads, ST_DRAIN
// takes the last read data and ST_DONE forms the result. busy is high from the
// transfer edge until rsp_valid rises, and the result is taken at the edge that
// ends the rsp_valid cycle. busy drops in the rsp_valid cycle, so another
// evaluate can be presented while the result is shown.
// the receiver has no stall: each result is shown for exactly one cycle.
// csr_wr_en writes active_polys from csr_wr_data at once; write it while idle.
// reset clears the sequencer, all term counts to zero and active_polys to 8.
// the term masks are not cleared; slots beyond a term count are never used.
module gf2_anf_polynomial_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic [2:0]                          req_poly_index,
   input  logic [3:0]                          req_term_index,
   input  logic [gf2anf_pkg::FIELD_W-1:0]      req_term_mask,
   input  logic [4:0]                          req_term_count,
   input  logic [gf2anf_pkg::FIELD_W-1:0]      req_input_bits,
   output logic                                rsp_valid,
   output logic [gf2anf_pkg::RESULT_W-1:0]     rsp_result_bits,
   input  logic                                csr_wr_en,
   input  logic [gf2anf_pkg::ACTIVE_W-1:0]     csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                              state_ff;
   logic [gf2anf_pkg::TERM_W-1:0]           slot_ff;
   logic                                    step_ff;
   logic [gf2anf_pkg::TERM_W-1:0]           step_slot_ff;
   logic [gf2anf_pkg::NUM_VARS-1:0]         vars_ff;
   logic                                    rsp_valid_ff;
   logic [gf2anf_pkg::RESULT_W-1:0]         rsp_bits_ff;
   logic [gf2anf_pkg::RESULT_W-1:0]         rsp_bits_in;
   logic [gf2anf_pkg::ACTIVE_W-1:0]         active_ff;
   gf2anf_pkg::count_vec_type               counts_ff;

   gf2anf_pkg::cmd_type                     cmd;
   logic                                    xfer;
   logic                                    mask_wr;
   logic                                    eval_go;
   logic                                    rd_en;
   gf2anf_pkg::mask_row_type                rd_row;
   gf2anf_pkg::acc_ctl_type                 acc_ctl;
   logic [gf2anf_pkg::NUM_POLYS-1:0]        acc;
   logic [gf2anf_pkg::CNT_W-1:0]            count_sat;

   assign cmd     = gf2anf_pkg::cmd_type'(req_command);
   assign busy    = (state_ff != ST_IDLE);
   assign xfer    = start && !busy;
   assign eval_go = xfer && (cmd == gf2anf_pkg::CMD_EVALUATE);
   assign mask_wr = xfer && (cmd == gf2anf_pkg::CMD_WRITE_MASK)
                    && (32'(req_poly_index) < gf2anf_pkg::NUM_POLYS)
                    && (32'(req_term_index) < gf2anf_pkg::MAX_TERMS);
   assign rd_en   = (state_ff == ST_RUN);

   assign count_sat = (32'(req_term_count) > gf2anf_pkg::MAX_TERMS) ?
                      gf2anf_pkg::CNT_W'(gf2anf_pkg::MAX_TERMS) :
                      gf2anf_pkg::CNT_W'(req_term_count);

   assign acc_ctl.clear = eval_go;
   assign acc_ctl.step  = step_ff;
   assign acc_ctl.slot  = step_slot_ff;

   gf2anf_term_store u_store (
      .clock   (clock),
      .wr_en   (mask_wr),
      .wr_poly (gf2anf_pkg::POLY_W'(req_poly_index)),
      .wr_term (gf2anf_pkg::TERM_W'(req_term_index)),
      .wr_mask (gf2anf_pkg::NUM_VARS'(req_term_mask & gf2anf_pkg::VAR_MASK)),
      .rd_en   (rd_en),
      .rd_term (slot_ff),
      .rd_row  (rd_row)
   );

   gf2anf_accum u_accum (
      .clock  (clock),
      .ctl    (acc_ctl),
      .row    (rd_row),
      .vars   (vars_ff),
      .counts (counts_ff),
      .acc    (acc)
   );

   // only polynomials below the active count and below NUM_POLYS report
   always_comb begin
      rsp_bits_in = '0;
      for (int p = 0; p < gf2anf_pkg::RESULT_W; p++) begin
         if ((p < gf2anf_pkg::NUM_POLYS) && (p < 32'(active_ff))) begin
            rsp_bits_in[p] = acc[p % gf2anf_pkg::NUM_POLYS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         step_ff      <= 1'b0;
         step_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= gf2anf_pkg::ACTIVE_W'(8);
         counts_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= rd_en;
         step_slot_ff <= slot_ff;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         if (xfer && (cmd == gf2anf_pkg::CMD_WRITE_COUNT)
             && (32'(req_poly_index) < gf2anf_pkg::NUM_POLYS)) begin
            counts_ff[gf2anf_pkg::POLY_W'(req_poly_index)] <= count_sat;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (eval_go) begin
                  vars_ff  <= gf2anf_pkg::NUM_VARS'(req_input_bits & gf2anf_pkg::VAR_MASK);
                  slot_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (32'(slot_ff) == gf2anf_pkg::MAX_TERMS - 1) begin
                  slot_ff  <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  slot_ff <= slot_ff + gf2anf_pkg::TERM_W'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_bits_ff  <= rsp_bits_in;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = rsp_bits_ff;

endmodule

@@ rtl/gf2anf_term_store.sv @@
// term mask memory: one row per term slot, one mask per polynomial in a row
// depends on gf2anf_pkg
module gf2anf_term_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [gf2anf_pkg::POLY_W-1:0]  wr_poly,
   input  logic [gf2anf_pkg::TERM_W-1:0]  wr_term,
   input  logic [gf2anf_pkg::NUM_VARS-1:0] wr_mask,
   input  logic                           rd_en,
   input  logic [gf2anf_pkg::TERM_W-1:0]  rd_term,
   output gf2anf_pkg::mask_row_type       rd_row
);

   gf2anf_pkg::mask_row_type mem_ff [gf2anf_pkg::MAX_TERMS];
   gf2anf_pkg::mask_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_term][wr_poly] <= wr_mask;
      end
      if (rd_en) begin
         rd_row_ff <= mem_ff[rd_term];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

@@ rtl/gf2anf_accum.sv @@
// shared monomial test and xor accumulator, one term slot of every polynomial per step
// depends on gf2anf_pkg
module gf2anf_accum (
   input  logic                            clock,
   input  gf2anf_pkg::acc_ctl_type         ctl,
   input  gf2anf_pkg::mask_row_type        row,
   input  logic [gf2anf_pkg::NUM_VARS-1:0] vars,
   input  gf2anf_pkg::count_vec_type       counts,
   output logic [gf2anf_pkg::NUM_POLYS-1:0] acc
);

   logic [gf2anf_pkg::NUM_POLYS-1:0] acc_ff;
   logic [gf2anf_pkg::NUM_POLYS-1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      for (int p = 0; p < gf2anf_pkg::NUM_POLYS; p++) begin
         if (ctl.step && ({1'b0, ctl.slot} < gf2anf_pkg::CNT_W'(counts[p]))
             && ((vars & row[p]) == row[p])) begin
            acc_in[p] = ~acc_ff[p];
         end
      end
      if (ctl.clear) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
